>>> hdl/msm_pkg.sv
`default_nettype none

package msm_pkg;

   // Block dimensions.
   localparam int CHANNELS    = 32;
   localparam int WINDOW      = 10;
   localparam int SAMPLE_BITS = 16;

   localparam int CH_BITS   = 5;
   localparam int CH_ABITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_BITS  = $clog2(WINDOW);
   localparam int FILL_BITS = $clog2(WINDOW + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
   localparam int WIN_DEPTH = CHANNELS * WINDOW;
   localparam int WIN_ABITS = $clog2(WIN_DEPTH);

   // Floored division of the running sum by the window length. The sum is
   // offset by a multiple of the window length so that it is never negative,
   // and the quotient is then taken by a reciprocal multiplication that is
   // exact for every sum the window can hold.
   localparam longint SUM_BIAS   = longint'(WINDOW) * (longint'(1) << (SAMPLE_BITS - 1));
   localparam int     DIV_SHIFT  = SUM_BITS + 4;
   localparam longint DIV_MULT   = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
   localparam int     MULT_BITS  = $clog2(DIV_MULT + 1);
   localparam int     PROD_BITS  = SUM_BITS + MULT_BITS;

   localparam logic [15:0] ERROR_LIMIT_RESET = 16'd20;

   // Command codes.
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_GOOD = 2'd1;
   localparam logic [1:0] CMD_BAD  = 2'd2;

   typedef struct packed {
      logic [1:0]                    cmd;
      logic [CH_BITS-1:0]            channel;
      logic signed [SAMPLE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [CH_BITS-1:0]            out_channel;
      logic signed [SAMPLE_BITS-1:0] window_average;
      logic                          sample_over;
      logic                          alert;
      logic                          overwrote;
      logic                          disconnected;
      logic [15:0]                   error_count;
      logic [15:0]                   over_count;
      logic [31:0]                   overwrite_count;
      logic signed [SAMPLE_BITS-1:0] peak_value;
      logic signed [SAMPLE_BITS-1:0] floor_value;
      logic [15:0]                   received_count;
   } rsp_type;

   // Per-channel record held in the channel memory.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] limit;
      logic signed [SUM_BITS-1:0]    sum;
      logic signed [SAMPLE_BITS-1:0] peak;
      logic signed [SAMPLE_BITS-1:0] low;
      logic [15:0]                   err_cnt;
      logic [15:0]                   over_cnt;
      logic [31:0]                   ovw_cnt;
      logic [15:0]                   rcv_cnt;
   } rec_type;

   // Per-channel ring control held in flip-flops.
   typedef struct packed {
      logic [POS_BITS-1:0]  pos;
      logic [FILL_BITS-1:0] fill;
      logic                 connected;
   } ctl_type;

endpackage

`default_nettype wire

>>> hdl/msm_ram.sv
`default_nettype none

module msm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]              read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

>>> hdl/msm_update.sv
`default_nettype none

module msm_update (
   input  wire msm_pkg::req_type                    req,
   input  wire msm_pkg::rec_type                    rec,
   input  wire msm_pkg::ctl_type                    ctl,
   input  wire logic signed [msm_pkg::SAMPLE_BITS-1:0] old_sample,
   input  wire logic [15:0]                         error_limit,
   output msm_pkg::rec_type                         rec_new,
   output msm_pkg::ctl_type                         ctl_new,
   output logic                                     win_write,
   output msm_pkg::rsp_type                         rsp
);

   import msm_pkg::*;

   logic signed [SAMPLE_BITS-1:0] old_v;
   logic signed [SUM_BITS-1:0]    sum_next;
   logic [SUM_BITS-1:0]           biased;
   logic [PROD_BITS-1:0]          product;
   logic [SAMPLE_BITS-1:0]        quotient;
   logic signed [SAMPLE_BITS-1:0] avg;
   logic                          full;
   logic                          over;
   logic                          alert;
   logic                          ovw;
   logic                          sample_done;
   logic [15:0]                   err_next;

   // An entry at or beyond the fill count has not been written since load.
   assign full  = (ctl.fill >= FILL_BITS'(WINDOW));
   assign old_v = full ? old_sample : '0;

   // Running sum after the sample replaces the oldest entry.
   assign sum_next = rec.sum + SUM_BITS'(req.value) - SUM_BITS'(old_v);

   // Floored average by offset and reciprocal multiplication.
   assign biased   = SUM_BITS'(sum_next) + SUM_BITS'(SUM_BIAS);
   assign product  = PROD_BITS'(biased) * PROD_BITS'(DIV_MULT);
   assign quotient = product[DIV_SHIFT +: SAMPLE_BITS];
   assign avg      = {~quotient[SAMPLE_BITS-1], quotient[SAMPLE_BITS-2:0]};

   assign err_next = (rec.err_cnt == 16'hFFFF) ? rec.err_cnt : rec.err_cnt + 16'd1;

   // Command decode and record update.
   always_comb begin
      rec_new     = rec;
      ctl_new     = ctl;
      win_write   = 1'b0;
      over        = 1'b0;
      alert       = 1'b0;
      ovw         = 1'b0;
      sample_done = 1'b0;
      unique case (req.cmd)
         CMD_LOAD: begin
            rec_new           = '0;
            rec_new.limit     = req.value;
            rec_new.low       = req.value;
            ctl_new.pos       = '0;
            ctl_new.fill      = '0;
            ctl_new.connected = 1'b1;
         end
         CMD_GOOD: begin
            if (ctl.connected) begin
               sample_done = 1'b1;
               win_write   = 1'b1;
               if (rec.rcv_cnt != 16'hFFFF) begin
                  rec_new.rcv_cnt = rec.rcv_cnt + 16'd1;
               end
               if (full) begin
                  ovw = 1'b1;
                  if (rec.ovw_cnt != 32'hFFFF_FFFF) begin
                     rec_new.ovw_cnt = rec.ovw_cnt + 32'd1;
                  end
               end else begin
                  ctl_new.fill = ctl.fill + FILL_BITS'(1);
               end
               rec_new.sum = sum_next;
               ctl_new.pos = (ctl.pos == POS_BITS'(WINDOW - 1)) ? '0 : ctl.pos + POS_BITS'(1);
               if (req.value > rec.peak) begin
                  rec_new.peak = req.value;
               end
               if (req.value < rec.low) begin
                  rec_new.low = req.value;
               end
               if (req.value > rec.limit) begin
                  over = 1'b1;
                  if (rec.over_cnt != 16'hFFFF) begin
                     rec_new.over_cnt = rec.over_cnt + 16'd1;
                  end
                  alert = (avg > rec.limit);
               end
            end
         end
         CMD_BAD: begin
            if (ctl.connected) begin
               if (rec.rcv_cnt != 16'hFFFF) begin
                  rec_new.rcv_cnt = rec.rcv_cnt + 16'd1;
               end
               rec_new.err_cnt = err_next;
               if (err_next > error_limit) begin
                  ctl_new.connected = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Status transaction.
   always_comb begin
      rsp.out_channel     = req.channel;
      rsp.window_average  = sample_done ? avg : '0;
      rsp.sample_over     = over;
      rsp.alert           = alert;
      rsp.overwrote       = ovw;
      rsp.disconnected    = ~ctl_new.connected;
      rsp.error_count     = rec_new.err_cnt;
      rsp.over_count      = rec_new.over_cnt;
      rsp.overwrite_count = rec_new.ovw_cnt;
      rsp.peak_value      = rec_new.peak;
      rsp.floor_value     = rec_new.low;
      rsp.received_count  = rec_new.rcv_cnt;
   end

endmodule

`default_nettype wire

>>> hdl/multichannel_sensor_monitor.sv
`default_nettype none

// Per-channel sensor monitor. Every request transaction (load limit, good
// sample or bad sample) yields exactly one status transaction after it is
// accepted, and a new request is not taken while one is in flight: the
// read stage reads the channel record and the window entry from their
// memories, the update stage updates them, writes them back and registers the
// status. The result register frees the request side whenever the previous
// status is taken in the same cycle. Window entries need no clearing after
// reset or load: entries beyond a channel's fill count read as zero.
module multichannel_sensor_monitor (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire msm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output msm_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [15:0]      csr_write_data
);

   import msm_pkg::*;

   logic [15:0]            limit_ff;
   ctl_type                ctl_ff [CHANNELS];
   logic [CHANNELS-1:0]    rec_valid_ff;
   logic                   s1_valid_ff;
   req_type                s1_req_ff;
   ctl_type                s1_ctl_ff;
   logic                   s1_rec_valid_ff;
   logic [WIN_ABITS-1:0]   s1_waddr_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   logic                   req_accept;
   logic [CH_ABITS-1:0]    req_ch;
   logic [CH_ABITS-1:0]    s1_ch;
   logic [WIN_ABITS-1:0]   win_raddr_in;
   logic [$bits(rec_type)-1:0] rec_rd;
   logic [SAMPLE_BITS-1:0] win_rd;
   rec_type                rec_cur;
   rec_type                rec_new;
   ctl_type                ctl_new;
   logic                   win_write;
   rsp_type                rsp_new;

   // Handshake: one transaction in flight, and the result register must be
   // free or emptying.
   assign req_stall  = s1_valid_ff | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;
   assign req_ch     = req_data.channel[CH_ABITS-1:0];
   assign s1_ch      = s1_req_ff.channel[CH_ABITS-1:0];

   // Window entry address of the channel's current ring position.
   assign win_raddr_in = WIN_ABITS'(req_ch) * WIN_ABITS'(WINDOW)
                       + WIN_ABITS'(ctl_ff[req_ch].pos);

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ERROR_LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // Read stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_req_ff       <= req_data;
         s1_ctl_ff       <= ctl_ff[req_ch];
         s1_rec_valid_ff <= rec_valid_ff[req_ch];
         s1_waddr_ff     <= win_raddr_in;
      end
   end

   msm_ram #(
      .WIDTH($bits(rec_type)),
      .DEPTH(CHANNELS)
   ) u_rec_ram (
      .clock         (clock),
      .write_enable  (s1_valid_ff),
      .write_address (s1_ch),
      .write_data    (rec_new),
      .read_address  (req_ch),
      .read_data     (rec_rd)
   );

   msm_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(WIN_DEPTH)
   ) u_win_ram (
      .clock         (clock),
      .write_enable  (s1_valid_ff & win_write),
      .write_address (s1_waddr_ff),
      .write_data    (s1_req_ff.value),
      .read_address  (win_raddr_in),
      .read_data     (win_rd)
   );

   // A record never written since reset reads as all zero.
   assign rec_cur = s1_rec_valid_ff ? rec_type'(rec_rd) : '0;

   msm_update u_update (
      .req         (s1_req_ff),
      .rec         (rec_cur),
      .ctl         (s1_ctl_ff),
      .old_sample  (win_rd),
      .error_limit (limit_ff),
      .rec_new     (rec_new),
      .ctl_new     (ctl_new),
      .win_write   (win_write),
      .rsp         (rsp_new)
   );

   // Write-back of ring control and record valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         rec_valid_ff[s1_ch] <= 1'b1;
         ctl_ff[s1_ch]       <= ctl_new;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_valid_ff) begin
         rsp_data_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> hdl/msm_checker.sv
`default_nettype none

module msm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire msm_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire msm_pkg::rsp_type rsp_data
);

   import msm_pkg::*;

   logic req_accept;
   assign req_accept = req_valid & ~req_stall;

   // A stalled status transaction is held.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("status transaction dropped while stalled");

   // Only one request is in flight at a time.
   a_interlock: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request accepted while another was in flight");

   // Every request produces a status for the same channel.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##2 (rsp_valid && rsp_data.out_channel == $past(req_data.channel, 2)))
      else $error("status transaction missing or for the wrong channel");

   // A load leaves the channel connected with cleared counters.
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.cmd == CMD_LOAD |-> ##2
         (!rsp_data.disconnected && rsp_data.error_count == 16'd0
          && rsp_data.received_count == 16'd0))
      else $error("load did not reset the channel status");

endmodule

bind multichannel_sensor_monitor msm_checker u_msm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write_enable;
   logic [15:0] csr_write_data;

   multichannel_sensor_monitor dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // Shadow copy of the per-channel state.
   logic [15:0] error_limit_shadow;
   logic signed [15:0] win_mem [CHANNELS][WINDOW];
   int unsigned pos_mem [CHANNELS];
   int unsigned fill_mem [CHANNELS];
   int signed sum_mem [CHANNELS];
   logic signed [15:0] limit_mem [CHANNELS];
   logic signed [15:0] peak_mem [CHANNELS];
   logic signed [15:0] low_mem [CHANNELS];
   logic [15:0] err_mem [CHANNELS];
   logic [15:0] over_mem [CHANNELS];
   logic [31:0] ovw_mem [CHANNELS];
   logic [15:0] rcv_mem [CHANNELS];
   logic connected_mem [CHANNELS];

   rsp_type status_queue [$];
   int fail_count;
   int unsigned cycle_count;
   bit hold_off;
   bit no_idle;

   // A row of the directed table; check_now means the status is typed in.
   typedef struct {
      req_type req;
      bit check_now;
      rsp_type status;
   } directed_row_type;

   task automatic clear_shadow();
      error_limit_shadow = ERROR_LIMIT_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
         for (int w = 0; w < WINDOW; w++) win_mem[c][w] = '0;
         pos_mem[c] = 0;
         fill_mem[c] = 0;
         sum_mem[c] = 0;
         limit_mem[c] = '0;
         peak_mem[c] = '0;
         low_mem[c] = '0;
         err_mem[c] = '0;
         over_mem[c] = '0;
         ovw_mem[c] = '0;
         rcv_mem[c] = '0;
         connected_mem[c] = 1'b0;
      end
   endtask

   function automatic logic [15:0] bump16(logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   // Works out the status for one request and updates the shadow state.
   function automatic rsp_type monitor_status(req_type r);
      rsp_type s;
      int ch;
      int signed v;
      int signed avg;
      s = '0;
      ch = r.channel;
      v = r.value;
      avg = 0;
      s.out_channel = r.channel;
      if (r.cmd == CMD_LOAD) begin
         limit_mem[ch] = r.value;
         for (int w = 0; w < WINDOW; w++) win_mem[ch][w] = '0;
         pos_mem[ch] = 0;
         fill_mem[ch] = 0;
         sum_mem[ch] = 0;
         peak_mem[ch] = '0;
         low_mem[ch] = r.value;
         err_mem[ch] = '0;
         over_mem[ch] = '0;
         ovw_mem[ch] = '0;
         rcv_mem[ch] = '0;
         connected_mem[ch] = 1'b1;
      end else if (r.cmd == CMD_GOOD && connected_mem[ch]) begin
         rcv_mem[ch] = bump16(rcv_mem[ch]);
         if (fill_mem[ch] >= WINDOW) begin
            s.overwrote = 1'b1;
            if (ovw_mem[ch] != 32'hFFFF_FFFF) ovw_mem[ch] = ovw_mem[ch] + 1;
         end else begin
            fill_mem[ch]++;
         end
         sum_mem[ch] += v - int'(win_mem[ch][pos_mem[ch]]);
         win_mem[ch][pos_mem[ch]] = r.value;
         pos_mem[ch] = (pos_mem[ch] + 1 >= WINDOW) ? 0 : pos_mem[ch] + 1;
         if (r.value > peak_mem[ch]) peak_mem[ch] = r.value;
         if (r.value < low_mem[ch]) low_mem[ch] = r.value;
         // Division rounded toward minus infinity.
         if (sum_mem[ch] >= 0) avg = sum_mem[ch] / WINDOW;
         else avg = -((-sum_mem[ch] + WINDOW - 1) / WINDOW);
         if (r.value > limit_mem[ch]) begin
            s.sample_over = 1'b1;
            over_mem[ch] = bump16(over_mem[ch]);
            if (avg > int'(limit_mem[ch])) s.alert = 1'b1;
         end
      end else if (r.cmd == CMD_BAD && connected_mem[ch]) begin
         rcv_mem[ch] = bump16(rcv_mem[ch]);
         err_mem[ch] = bump16(err_mem[ch]);
         if (err_mem[ch] > error_limit_shadow) connected_mem[ch] = 1'b0;
      end
      s.window_average = 16'(avg);
      s.disconnected = !connected_mem[ch];
      s.error_count = err_mem[ch];
      s.over_count = over_mem[ch];
      s.overwrite_count = ovw_mem[ch];
      s.peak_value = peak_mem[ch];
      s.floor_value = low_mem[ch];
      s.received_count = rcv_mem[ch];
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
               want);
      fail_count++;
   endtask

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Cycle counter with a run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver stall: random, never in a no-idle phase, or held off entirely during a pressure phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 27);
      end
   end

   // Each accepted status transaction is compared with the oldest expected one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_queue.size() == 0) begin
            report_mismatch("unexpected status", 32'(rsp_data.out_channel), 0);
         end else begin
            want = status_queue.pop_front();
            if (rsp_data.out_channel !== want.out_channel)
               report_mismatch("out_channel", 32'(rsp_data.out_channel),
                               32'(want.out_channel));
            if (rsp_data.window_average !== want.window_average)
               report_mismatch("window_average", 32'(rsp_data.window_average),
                               32'(want.window_average));
            if (rsp_data.sample_over !== want.sample_over)
               report_mismatch("sample_over", 32'(rsp_data.sample_over),
                               32'(want.sample_over));
            if (rsp_data.alert !== want.alert)
               report_mismatch("alert", 32'(rsp_data.alert), 32'(want.alert));
            if (rsp_data.overwrote !== want.overwrote)
               report_mismatch("overwrote", 32'(rsp_data.overwrote), 32'(want.overwrote));
            if (rsp_data.disconnected !== want.disconnected)
               report_mismatch("disconnected", 32'(rsp_data.disconnected),
                               32'(want.disconnected));
            if (rsp_data.error_count !== want.error_count)
               report_mismatch("error_count", 32'(rsp_data.error_count),
                               32'(want.error_count));
            if (rsp_data.over_count !== want.over_count)
               report_mismatch("over_count", 32'(rsp_data.over_count),
                               32'(want.over_count));
            if (rsp_data.overwrite_count !== want.overwrite_count)
               report_mismatch("overwrite_count", rsp_data.overwrite_count,
                               want.overwrite_count);
            if (rsp_data.peak_value !== want.peak_value)
               report_mismatch("peak_value", 32'(rsp_data.peak_value),
                               32'(want.peak_value));
            if (rsp_data.floor_value !== want.floor_value)
               report_mismatch("floor_value", 32'(rsp_data.floor_value),
                               32'(want.floor_value));
            if (rsp_data.received_count !== want.received_count)
               report_mismatch("received_count", 32'(rsp_data.received_count),
                               32'(want.received_count));
         end
      end
   end

   // Offers one request transaction, with an optional random gap first. The
   // valid stays high after acceptance until the next gap or idle period.
   task automatic send_request(req_type r, bit check_now, rsp_type typed);
      rsp_type predicted;
      while (!no_idle && ($urandom_range(99) < 27)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = monitor_status(r);
      if (check_now && predicted !== typed)
         report_mismatch("typed-in status disagrees", 32'(r.channel), 0);
      status_queue.push_back(predicted);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_error_limit(logic [15:0] lim);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= lim;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      error_limit_shadow = lim;
   endtask

   function automatic req_type make_req(logic [1:0] cmd, int ch, logic [15:0] v);
      req_type r;
      r.cmd = cmd;
      r.channel = 5'(ch);
      r.value = v;
      return r;
   endfunction

   // Status after a load, or of a channel never loaded.
   function automatic rsp_type plain_status(int ch, bit disc, logic [15:0] low);
      rsp_type s;
      s = '0;
      s.out_channel = 5'(ch);
      s.disconnected = disc;
      s.floor_value = low;
      return s;
   endfunction

   // Random request: mostly good samples on the first nch channels, all of them loaded.
   function automatic req_type random_req(int nch);
      req_type r;
      int pick;
      r.channel = 5'($urandom_range(nch - 1));
      pick = $urandom_range(99);
      if (pick < 4) r.cmd = CMD_LOAD;
      else if (pick < 78) r.cmd = CMD_GOOD;
      else if (pick < 96) r.cmd = CMD_BAD;
      else r.cmd = CMD_SPARE;
      case ($urandom_range(3))
         0: r.value = 16'($urandom);
         1: r.value = 16'($urandom_range(2000)) - 16'd1000;
         2: r.value = ($urandom_range(1)) ? 16'h7FFF - 16'($urandom_range(50))
                                         : 16'h8000 + 16'($urandom_range(50));
         default: r.value = 16'($urandom_range(200));
      endcase
      return r;
   endfunction

   initial begin
      directed_row_type rows [$];
      directed_row_type row;
      int phase_items;
      int nch;
      logic [15:0] limits [4];

      fail_count = 0;
      cycle_count = 0;
      hold_off = 1'b0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      clear_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: unloaded channel, extremes, every command.
      rows.push_back('{make_req(CMD_GOOD, 3, 16'h1234), 1, plain_status(3, 1, 0)});
      rows.push_back('{make_req(CMD_BAD, 31, 16'h0), 1, plain_status(31, 1, 0)});
      rows.push_back('{make_req(CMD_LOAD, 0, 16'h7FFF), 1, plain_status(0, 0, 16'h7FFF)});
      rows.push_back('{make_req(CMD_LOAD, 31, 16'h8000), 1, plain_status(31, 0, 16'h8000)});
      rows.push_back('{make_req(CMD_LOAD, 5, 16'd100), 1, plain_status(5, 0, 16'd100)});
      rows.push_back('{make_req(CMD_GOOD, 0, 16'h8000), 0, '0});
      rows.push_back('{make_req(CMD_GOOD, 0, 16'h7FFF), 0, '0});
      rows.push_back('{make_req(CMD_SPARE, 0, 16'hFFFF), 0, '0});
      for (int i = 0; i < 12; i++)
         rows.push_back('{make_req(CMD_GOOD, 31, 16'h7FFF), 0, '0});
      rows.push_back('{make_req(CMD_GOOD, 5, 16'hFFFF), 0, '0});
      rows.push_back('{make_req(CMD_BAD, 5, 16'h5555), 0, '0});
      rows.push_back('{make_req(CMD_GOOD, 5, 16'd500), 0, '0});
      foreach (rows[i]) begin
         row = rows[i];
         send_request(row.req, row.check_now, row.status);
      end

      // Disconnection with a zero error limit, then recovery by a load.
      write_error_limit(16'd0);
      send_request(make_req(CMD_BAD, 5, 16'h0), 0, '0);
      send_request(make_req(CMD_GOOD, 5, 16'd7), 0, '0);
      send_request(make_req(CMD_LOAD, 5, 16'h0), 1, plain_status(5, 0, 0));

      // Random phases over several error limits; the last never disconnects.
      limits = '{16'd3, 16'd20, 16'd0, 16'hFFFF};
      for (int p = 0; p < 4; p++) begin
         write_error_limit(limits[p]);
         nch = (p == 1) ? 32 : 4;
         for (int c = 0; c < nch; c++)
            send_request(make_req(CMD_LOAD, c, 16'($urandom_range(400)) - 16'd100), 0, '0);
         no_idle = (p == 2);
         phase_items = 250;
         for (int i = 0; i < phase_items; i++) begin
            // Long receiver hold-off while requests keep coming.
            if (p == 1 && i == 100) begin
               fork
                  begin
                     hold_off = 1'b1;
                     repeat (60) @(posedge clock);
                     hold_off = 1'b0;
                  end
               join_none
            end
            send_request(random_req(nch), 0, '0);
         end
         no_idle = 1'b0;
      end

      // Drain and finish.
      req_valid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

`default_nettype wire
